FILE: src/min_heap_priority_queue_defines.svh
// Assertion macros shared by the heap queue RTL.
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Concurrent check of a property at every clock edge outside reset.
`define MHPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check in the cycle after a trigger.
`define MHPQ_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

FILE: src/mhpq_pkg.sv
// Package: widths, codes and state type of the min-heap priority queue.
`timescale 1ns / 1ps
package mhpq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 11;

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN,
        S_DN_CMP,
        S_RESP
    } t_state;

endpackage

FILE: src/mhpq_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
`timescale 1ns / 1ps
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: src/min_heap_priority_queue.sv
// Top level: binary min-heap priority queue of signed keys over one heap RAM.
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one operation per transfer:
//   i_kind 0 inserts i_key_in, 1 extracts the minimum. Output channel
//   (o_out_valid / i_out_stall) returns exactly one result per operation:
//   removed key, status (done / full / empty), root key and element count.
//   An insert climbs by the read-compare-write loop on the single heap RAM: per
//   level a parent read (S_UP), then a compare and write (S_UP_CMP). An extract
//   loads the last key (S_DN_LOAD) and sinks it: per level a read of both
//   children (S_DN), then a compare and write (S_DN_CMP). The key moves at most
//   log2(CAPACITY) levels; full and empty cases go straight to the response step
//   (S_RESP). The block then returns to idle before it takes the next transfer.
//   One operation is in flight at a time; o_in_stall is low only when idle.
//   A finished result sits in the output register, so the next operation is
//   taken while the receiver stalls; that operation waits at its end until
//   the output register is free.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any pending
//   result. Heap RAM is never cleared: data read from unoccupied slots is never used.
`timescale 1ns / 1ps
`include "min_heap_priority_queue_defines.svh"
module min_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_kind,
    input  logic signed [mhpq_pkg::KEY_W-1:0]      i_key_in,
    // output channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [mhpq_pkg::KEY_W-1:0]      o_extracted_key,
    output logic        [mhpq_pkg::STATUS_W-1:0]   o_status,
    output logic signed [mhpq_pkg::KEY_W-1:0]      o_current_min,
    output logic        [mhpq_pkg::COUNT_OUT_W-1:0] o_element_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CW1    = CNT_W + 1;
    localparam int KW     = mhpq_pkg::KEY_W;

    // control state
    mhpq_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_out_valid, n_out_valid;
    // working registers
    logic [CNT_W-1:0]  r_pos, n_pos;        // current slot (1-based)
    logic [KW-1:0]     r_key, n_key;        // key being sifted
    logic [KW-1:0]     r_taken, n_taken;    // key removed by extract
    mhpq_pkg::t_status r_status, n_status;
    logic [KW-1:0]     r_min, n_min;        // shadow copy of slot 1
    // output registers
    logic [KW-1:0]     r_out_key, n_out_key;
    logic [mhpq_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [KW-1:0]     r_out_min, n_out_min;
    logic [mhpq_pkg::COUNT_OUT_W-1:0] r_out_cnt, n_out_cnt;

    // RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [KW-1:0]     ram_wdata, ram_rdata_a, ram_rdata_b;

    // sift-down helpers
    logic [CW1-1:0]    c_left;
    logic              has_right, pick_right;
    logic [KW-1:0]     child_val;
    logic [CW1-1:0]    child_slot;
    logic [31:0]       cnt_ext;

    mhpq_ram #(
        .WIDTH (KW),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    assign o_in_stall      = (r_state != mhpq_pkg::S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_extracted_key = r_out_key;
    assign o_status        = r_out_status;
    assign o_current_min   = r_out_min;
    assign o_element_count = r_out_cnt;

    // children of r_pos; right child present unless left is the last slot
    assign c_left     = {r_pos, 1'b0};
    assign has_right  = (c_left != {1'b0, r_count});
    assign pick_right = has_right && !($signed(ram_rdata_a) < $signed(ram_rdata_b));
    assign child_val  = pick_right ? ram_rdata_b : ram_rdata_a;
    assign child_slot = pick_right ? (c_left + CW1'(1)) : c_left;
    assign cnt_ext    = 32'(r_count);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_pos        = r_pos;
        n_key        = r_key;
        n_taken      = r_taken;
        n_status     = r_status;
        n_out_key    = r_out_key;
        n_out_status = r_out_status;
        n_out_min    = r_out_min;
        n_out_cnt    = r_out_cnt;
        ram_we       = 1'b0;
        ram_waddr    = ADDR_W'(r_pos - CNT_W'(1));
        ram_wdata    = r_key;
        ram_raddr_a  = ADDR_W'(r_count - CNT_W'(1));   // last slot, for extract
        ram_raddr_b  = ADDR_W'(c_left);                // right child slot - 1

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_key    = i_key_in;
                    n_taken  = '0;
                    n_status = mhpq_pkg::ST_DONE;
                    if (i_kind == mhpq_pkg::KIND_INSERT) begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_status = mhpq_pkg::ST_FULL;
                            n_state  = mhpq_pkg::S_RESP;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_pos   = r_count + CNT_W'(1);
                            n_state = mhpq_pkg::S_UP;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mhpq_pkg::ST_EMPTY;
                            n_state  = mhpq_pkg::S_RESP;
                        end else begin
                            n_taken = r_min;
                            n_count = r_count - CNT_W'(1);
                            n_state = mhpq_pkg::S_DN_LOAD;
                        end
                    end
                end
            end
            mhpq_pkg::S_UP: begin
                if (r_pos == CNT_W'(1)) begin
                    ram_we  = 1'b1;
                    n_state = mhpq_pkg::S_RESP;
                end else begin
                    ram_raddr_a = ADDR_W'((r_pos >> 1) - CNT_W'(1));
                    n_state     = mhpq_pkg::S_UP_CMP;
                end
            end
            mhpq_pkg::S_UP_CMP: begin
                ram_we = 1'b1;
                if ($signed(r_key) < $signed(ram_rdata_a)) begin
                    // parent moves down into the hole
                    ram_wdata = ram_rdata_a;
                    n_pos     = r_pos >> 1;
                    n_state   = mhpq_pkg::S_UP;
                end else begin
                    n_state = mhpq_pkg::S_RESP;
                end
            end
            mhpq_pkg::S_DN_LOAD: begin
                // last key arrives from the read issued at transfer
                n_key   = ram_rdata_a;
                n_pos   = CNT_W'(1);
                n_state = mhpq_pkg::S_DN;
            end
            mhpq_pkg::S_DN: begin
                if (c_left > {1'b0, r_count}) begin
                    ram_we  = 1'b1;
                    n_state = mhpq_pkg::S_RESP;
                end else begin
                    ram_raddr_a = ADDR_W'(c_left - CW1'(1));
                    ram_raddr_b = ADDR_W'(c_left);
                    n_state     = mhpq_pkg::S_DN_CMP;
                end
            end
            mhpq_pkg::S_DN_CMP: begin
                ram_we = 1'b1;
                if ($signed(child_val) < $signed(r_key)) begin
                    // smaller child moves up into the hole
                    ram_wdata = child_val;
                    n_pos     = CNT_W'(child_slot);
                    n_state   = mhpq_pkg::S_DN;
                end else begin
                    n_state = mhpq_pkg::S_RESP;
                end
            end
            mhpq_pkg::S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_key    = r_taken;
                    n_out_status = r_status;
                    n_out_min    = (r_count != '0) ? r_min : '0;
                    n_out_cnt    = cnt_ext[mhpq_pkg::COUNT_OUT_W-1:0];
                    n_state      = mhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mhpq_pkg::S_IDLE;
            end
        endcase

        // keep the root shadow in step with slot 1
        n_min = r_min;
        if (ram_we && (ram_waddr == '0)) begin
            n_min = ram_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhpq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_taken      <= n_taken;
        r_status     <= n_status;
        r_min        <= n_min;
        r_out_key    <= n_out_key;
        r_out_status <= n_out_status;
        r_out_min    <= n_out_min;
        r_out_cnt    <= n_out_cnt;
    end

    // checks
    `MHPQ_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY), "element count above capacity")
    `MHPQ_ASSERT_NEXT(a_result_from_resp,
        !r_out_valid && n_out_valid, r_state == mhpq_pkg::S_IDLE,
        "result loaded outside response step")
    `MHPQ_ASSERT(a_empty_no_key,
        (r_state == mhpq_pkg::S_RESP) && (r_status != mhpq_pkg::ST_DONE) |-> (r_taken == '0),
        "failed operation carries a key")

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the min-heap priority queue: directed table, then random traffic.
`timescale 1ns / 1ps
module testbench;

    localparam int KEY_W       = mhpq_pkg::KEY_W;
    localparam int STATUS_W    = mhpq_pkg::STATUS_W;
    localparam int COUNT_OUT_W = mhpq_pkg::COUNT_OUT_W;
    localparam int HEAP_DEPTH  = mhpq_pkg::CAPACITY_DEF;
    localparam int MAX_GAP = 12;
    localparam int DRAIN_CYCLES = 30;     // settle margin after the last expected result is checked
    localparam int CYCLE_LIMIT = 500_000;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_ZERO = 32'sh0000_0000;
    localparam logic signed [KEY_W-1:0] KEY_NEG1 = 32'shFFFF_FFFF;

    typedef struct packed {
        logic signed [KEY_W-1:0]   extracted_key;
        mhpq_pkg::t_status         status;
        logic signed [KEY_W-1:0]   current_min;
        logic [COUNT_OUT_W-1:0]    element_count;
    } t_heap_result;

    typedef struct {
        logic         kind;
        logic signed [KEY_W-1:0] key;
        bit           pinned;     // expected result typed in by hand
        t_heap_result res;
    } t_op_row;

    // DUT ports
    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_kind = mhpq_pkg::KIND_INSERT;
    logic signed [KEY_W-1:0]    i_key_in = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [KEY_W-1:0]    o_extracted_key;
    logic [STATUS_W-1:0]        o_status;
    logic signed [KEY_W-1:0]    o_current_min;
    logic [COUNT_OUT_W-1:0]     o_element_count;

    min_heap_priority_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_kind(i_kind),
        .i_key_in(i_key_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_extracted_key(o_extracted_key),
        .o_status(o_status),
        .o_current_min(o_current_min),
        .o_element_count(o_element_count)
    );

    // Shadow heap
    logic signed [KEY_W-1:0] heap_mem [1:HEAP_DEPTH];
    int heap_fill = 0;

    t_heap_result expected_q[$];
    t_op_row      pinned_q[$];
    t_op_row      dir_rows[$];

    int  err_count = 0;
    int  n_checked = 0;
    int  n_ops = 0;
    int  n_dropped = 0;
    int  n_empty = 0;
    int  peak_fill = 0;
    int  cycle_cnt = 0;
    int  sent_level = 0;   // driver-side fill tally, used only to steer phases
    int  ops_sent = 0;
    bit  no_gaps = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void heap_swap(int a, int b);
        logic signed [KEY_W-1:0] t;
        t = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    // Apply one operation to the shadow heap and return the result it should produce.
    function automatic t_heap_result heap_apply(logic kind, logic signed [KEY_W-1:0] key);
        t_heap_result r;
        int pos;
        int c;
        r.extracted_key = '0;
        r.status = mhpq_pkg::ST_DONE;
        if (kind == mhpq_pkg::KIND_INSERT) begin
            if (heap_fill >= HEAP_DEPTH) begin
                r.status = mhpq_pkg::ST_FULL;
            end else begin
                heap_fill++;
                heap_mem[heap_fill] = key;
                pos = heap_fill;
                while (pos > 1) begin
                    if (!(heap_mem[pos] < heap_mem[pos / 2])) break;
                    heap_swap(pos, pos / 2);
                    pos = pos / 2;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                r.status = mhpq_pkg::ST_EMPTY;
            end else begin
                r.extracted_key = heap_mem[1];
                heap_mem[1] = heap_mem[heap_fill];
                heap_fill--;
                // sift down over occupied slots only; ties go to the right child
                pos = 1;
                while (2 * pos <= heap_fill) begin
                    c = 2 * pos;
                    if (c != heap_fill && !(heap_mem[c] < heap_mem[c + 1])) c = c + 1;
                    if (!(heap_mem[c] < heap_mem[pos])) break;
                    heap_swap(pos, c);
                    pos = c;
                end
            end
        end
        r.current_min = (heap_fill > 0) ? heap_mem[1] : '0;
        r.element_count = heap_fill[COUNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic log_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        err_count++;
    endtask

    // Result checking and prediction, both on sampled (pre-edge) values
    always @(posedge i_clk) begin
        t_heap_result want;
        t_heap_result pred;
        t_op_row row;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (expected_q.size() == 0) begin
                log_mismatch("result transfer with nothing outstanding");
            end else begin
                want = expected_q.pop_front();
                n_checked++;
                if (o_extracted_key !== want.extracted_key)
                    log_mismatch($sformatf("extracted_key %0d, want %0d",
                                           o_extracted_key, want.extracted_key));
                if (o_status !== want.status)
                    log_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
                if (o_current_min !== want.current_min)
                    log_mismatch($sformatf("current_min %0d, want %0d",
                                           o_current_min, want.current_min));
                if (o_element_count !== want.element_count)
                    log_mismatch($sformatf("element_count %0d, want %0d",
                                           o_element_count, want.element_count));
            end
        end
        if (i_rst_n && i_in_valid && o_in_stall === 1'b0) begin
            pred = heap_apply(i_kind, i_key_in);
            n_ops++;
            if (pred.status == mhpq_pkg::ST_FULL) n_dropped++;
            if (pred.status == mhpq_pkg::ST_EMPTY) n_empty++;
            if (heap_fill > peak_fill) peak_fill = heap_fill;
            if (pinned_q.size() != 0) begin
                row = pinned_q.pop_front();
                expected_q.push_back(row.pinned ? row.res : pred);
            end else begin
                expected_q.push_back(pred);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: random stall before each result
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            n = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // One input transfer; returns at the edge where it was taken.
    task automatic send_op(logic kind, logic signed [KEY_W-1:0] key);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_key_in <= key;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (kind == mhpq_pkg::KIND_INSERT && sent_level < HEAP_DEPTH) sent_level++;
        if (kind == mhpq_pkg::KIND_EXTRACT && sent_level > 0) sent_level--;
        ops_sent++;
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 7))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2, 3: return $signed(32'($urandom_range(0, 8))) - 32'sd4;  // dense, many ties
            default: return $signed($urandom);
        endcase
    endfunction

    task automatic random_op(int insert_pct);
        logic kind;
        if (ops_sent % 64 == 0) no_gaps = ($urandom_range(0, 4) == 0);
        kind = ($urandom_range(0, 99) < insert_pct) ? mhpq_pkg::KIND_INSERT
                                                    : mhpq_pkg::KIND_EXTRACT;
        send_op(kind, pick_key());
    endtask

    function automatic void add_row(logic kind, logic signed [KEY_W-1:0] key, bit pinned,
                                    logic signed [KEY_W-1:0] xk, mhpq_pkg::t_status st,
                                    logic signed [KEY_W-1:0] mn, int cnt);
        t_op_row r;
        r.kind = kind;
        r.key = key;
        r.pinned = pinned;
        r.res.extracted_key = xk;
        r.res.status = st;
        r.res.current_min = mn;
        r.res.element_count = cnt[COUNT_OUT_W-1:0];
        dir_rows.push_back(r);
    endfunction

    initial begin
        // directed table; pinned rows carry a hand-written result
        add_row(mhpq_pkg::KIND_EXTRACT, KEY_MIN,  1, KEY_ZERO, mhpq_pkg::ST_EMPTY, KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_INSERT,  KEY_MAX,  1, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_MAX,  1);
        add_row(mhpq_pkg::KIND_INSERT,  KEY_MIN,  1, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_MIN,  2);
        add_row(mhpq_pkg::KIND_EXTRACT, KEY_ZERO, 1, KEY_MIN,  mhpq_pkg::ST_DONE,  KEY_MAX,  1);
        add_row(mhpq_pkg::KIND_EXTRACT, KEY_ZERO, 1, KEY_MAX,  mhpq_pkg::ST_DONE,  KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_EXTRACT, KEY_MAX,  1, KEY_ZERO, mhpq_pkg::ST_EMPTY, KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_INSERT,  32'sd5,   1, KEY_ZERO, mhpq_pkg::ST_DONE,  32'sd5,   1);
        add_row(mhpq_pkg::KIND_INSERT,  32'sd5,   1, KEY_ZERO, mhpq_pkg::ST_DONE,  32'sd5,   2);
        add_row(mhpq_pkg::KIND_INSERT,  32'sd5,   1, KEY_ZERO, mhpq_pkg::ST_DONE,  32'sd5,   3);
        add_row(mhpq_pkg::KIND_INSERT,  KEY_NEG1, 1, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_NEG1, 4);
        add_row(mhpq_pkg::KIND_INSERT,  32'sd3,   0, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_INSERT,  32'sd3,   0, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_INSERT,  32'sd7,   0, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_EXTRACT, KEY_ZERO, 1, KEY_NEG1, mhpq_pkg::ST_DONE,  32'sd3,   6);
        // ties among the fives and threes exercise equal-child selection
        repeat (5) add_row(mhpq_pkg::KIND_EXTRACT, KEY_ZERO, 0, KEY_ZERO, mhpq_pkg::ST_DONE,
                           KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_EXTRACT, KEY_MAX,  1, 32'sd7,   mhpq_pkg::ST_DONE,  KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_INSERT,  KEY_MIN,  0, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_INSERT,  KEY_ZERO, 0, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_INSERT,  KEY_NEG1, 0, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_EXTRACT, KEY_ZERO, 0, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_ZERO, 0);
        add_row(mhpq_pkg::KIND_EXTRACT, KEY_MIN,  0, KEY_ZERO, mhpq_pkg::ST_DONE,  KEY_ZERO, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            pinned_q.push_back(dir_rows[i]);
            send_op(dir_rows[i].kind, dir_rows[i].key);
        end

        // balanced walk near empty: frequent empty extracts
        repeat (120) random_op(50);
        // fill to capacity with deep sift-ups
        while (sent_level < HEAP_DEPTH) random_op(97);
        // hover at full: dropped inserts and deep sift-downs
        repeat (200) random_op(60);

        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d operations, %0d results checked, peak fill %0d of %0d.",
                 n_ops, n_checked, peak_fill, HEAP_DEPTH);
        $display("Inserts dropped at full: %0d, extracts on empty heap: %0d, mismatches: %0d.",
                 n_dropped, n_empty, err_count);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
